/* sv/polygon_normal_and_area_macros.svh */
// ----------------------------------------------------------------------------
// Polygon normal and area assertion macros
// Immediate-consequence and next-cycle property macros; compiled out when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef POLYGON_NORMAL_AND_AREA_MACROS_SVH
`define POLYGON_NORMAL_AND_AREA_MACROS_SVH
`ifndef NO_ASSERTIONS
// consequence holds in the same cycle
`define PNA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pna: property violated");
// consequence holds in the next cycle
`define PNA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pna: property violated");
`else
`define PNA_ASSERT_NOW(label, ante, cons)
`define PNA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* sv/pna_pkg.sv */
// ----------------------------------------------------------------------------
// Polygon normal and area package
// Field widths, reset values, sequencer states and multiplier op kinds.
// ----------------------------------------------------------------------------
package pna_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int FACE_BITS      = 16;
    localparam int NORM_BITS      = 16;
    localparam int NORM_FRAC      = 14;
    localparam int TOL_BITS       = 50;
    localparam logic [TOL_BITS-1:0] TOL_RESET = 50'd17;
    localparam int AREA_BITS      = 56;
    // multiplier schedule: six cross terms, then three parts per square
    localparam int OP_COUNT       = 15;
    localparam int OP_CROSS_COUNT = 6;
    localparam int STEP_BITS      = 4;

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_MUL     = 8'b0000_0010,
        ST_ACC     = 8'b0000_0100,
        ST_SQRT    = 8'b0000_1000,
        ST_AREA    = 8'b0001_0000,
        ST_DIV_SET = 8'b0010_0000,
        ST_DIV     = 8'b0100_0000,
        ST_DONE    = 8'b1000_0000
    } state_t;

    typedef enum logic [1:0] {
        OP_CROSS  = 2'd0,
        OP_SQ_LO  = 2'd1,
        OP_SQ_MID = 2'd2,
        OP_SQ_HI  = 2'd3
    } op_kind_t;

endpackage

/* sv/polygon_normal_and_area.sv */
// ----------------------------------------------------------------------------
// Polygon normal and area
// Fan-triangulated face area and unit normal of the first triangle.
// ----------------------------------------------------------------------------
// Vertices arrive one item at a time; last_vertex closes the face and yields
// one result item. The first two vertices of a face are only taken in the
// idle state. Every further vertex is taken in the idle state, then one
// shared multiplier forms the cross product and the sum of its squares, each
// product in a multiply and an accumulate state, then a digit-by-digit square
// root makes one root bit per cycle for its R = 2*COORD_BITS + 4 bits, and
// the area state adds the area. Closing a face passes the done state, after
// a division set-up state when the face has a triangle, and after a set-up
// and a restoring division per component when the normal is valid; the done
// state waits while an earlier result is still held. in_ready is high only
// while the sequencer is idle; the result sits in an output register, so a
// new face can start while the previous result waits.
`include "polygon_normal_and_area_macros.svh"

module polygon_normal_and_area #(
    parameter int COORD_BITS = pna_pkg::COORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [pna_pkg::TOL_BITS-1:0]        cfg_write_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [pna_pkg::FACE_BITS-1:0]       face_id,
    input  logic signed [COORD_BITS-1:0]        x_coord,
    input  logic signed [COORD_BITS-1:0]        y_coord,
    input  logic signed [COORD_BITS-1:0]        z_coord,
    input  logic                                last_vertex,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [pna_pkg::FACE_BITS-1:0]       result_face,
    output logic signed [pna_pkg::NORM_BITS-1:0] normal_x,
    output logic signed [pna_pkg::NORM_BITS-1:0] normal_y,
    output logic signed [pna_pkg::NORM_BITS-1:0] normal_z,
    output logic                                normal_valid,
    output logic [pna_pkg::AREA_BITS-1:0]       area,
    output logic                                area_saturated
);
    import pna_pkg::*;

    localparam int W    = COORD_BITS + 1;      // edge vector
    localparam int CS   = 2 * W + 2;           // signed cross component
    localparam int C    = 2 * W + 1;           // cross magnitude
    localparam int H    = W + 1;               // multiplier operand
    localparam int S    = 2 * C + 2;           // sum of squares
    localparam int R    = C + 1;               // root
    localparam int CNT_BITS = $clog2(R);
    localparam int NW   = C + NORM_FRAC + 2;   // division remainder
    localparam int QW   = NORM_FRAC + 1;
    localparam int LW   = ((R > AREA_BITS + 1) ? R : AREA_BITS + 1) + 1;
    localparam int TW   = (R > TOL_BITS) ? R : TOL_BITS;

    state_t                     state_reg, state_next;
    logic [TOL_BITS-1:0]        tol_reg, tol_next;
    logic signed [COORD_BITS-1:0] first_reg [3];
    logic signed [COORD_BITS-1:0] first_next [3];
    logic signed [COORD_BITS-1:0] prev_reg [3];
    logic signed [COORD_BITS-1:0] prev_next [3];
    logic signed [W-1:0]        u_reg [3];
    logic signed [W-1:0]        u_next [3];
    logic signed [W-1:0]        v_reg [3];
    logic signed [W-1:0]        v_next [3];
    logic signed [CS-1:0]       cross_reg [3];
    logic signed [CS-1:0]       cross_next [3];
    logic signed [CS-1:0]       fcross_reg [3];
    logic signed [CS-1:0]       fcross_next [3];
    logic [R-1:0]               flen_reg, flen_next;
    logic [1:0]                 seen_reg, seen_next;
    logic [AREA_BITS-1:0]       area_reg, area_next;
    logic                       sat_reg, sat_next;
    logic [FACE_BITS-1:0]       face_reg, face_next;
    logic                       last_reg, last_next;
    logic [STEP_BITS-1:0]       step_reg, step_next;
    logic [2*H-1:0]             prod_reg, prod_next;
    logic [S-1:0]               sumsq_reg, sumsq_next;
    logic [R+2:0]               rem_reg, rem_next;
    logic [R-1:0]               root_reg, root_next;
    logic [CNT_BITS-1:0]        cnt_reg, cnt_next;
    logic [1:0]                 comp_reg, comp_next;
    logic [NW-1:0]              drem_reg, drem_next;
    logic [NW-1:0]              dsh_reg, dsh_next;
    logic [QW-1:0]              q_reg, q_next;
    logic signed [NORM_BITS-1:0] norm_reg [3];
    logic signed [NORM_BITS-1:0] norm_next [3];
    logic                       out_valid_reg, out_valid_next;
    logic [FACE_BITS-1:0]       o_face_reg, o_face_next;
    logic signed [NORM_BITS-1:0] o_norm_reg [3];
    logic signed [NORM_BITS-1:0] o_norm_next [3];
    logic                       o_nvalid_reg, o_nvalid_next;
    logic [AREA_BITS-1:0]       o_area_reg, o_area_next;
    logic                       o_sat_reg, o_sat_next;

    // multiplier operand decode
    op_kind_t                   op_kind;
    logic [1:0]                 op_ia, op_ib, op_comp;
    logic                       op_sub;
    logic signed [W-1:0]        opu, opv;
    logic [W-1:0]               opu_mag, opv_mag;
    logic signed [CS-1:0]       sq_src;
    logic [CS-1:0]              sq_abs;
    logic [C-1:0]               sq_mag;
    logic [H-1:0]               mul_a, mul_b;
    logic                       prod_neg;

    // misc datapath
    logic signed [COORD_BITS-1:0] pin [3];
    logic [R+2:0]               rem_sh, trial;
    logic                       root_ge;
    logic [LW-1:0]              len_ext, half;
    logic                       len_big;
    logic [AREA_BITS+1:0]       area_sum;
    logic                       face_full, face_nvalid;
    logic [CS-1:0]              div_abs;
    logic                       div_ge;
    logic [QW-1:0]              q_fin;
    logic                       out_free;

    assign pin[0] = x_coord;
    assign pin[1] = y_coord;
    assign pin[2] = z_coord;

    // schedule of the shared multiplier
    always_comb
    begin
        op_kind = OP_CROSS;
        op_ia   = 2'd0;
        op_ib   = 2'd0;
        op_comp = 2'd0;
        op_sub  = 1'b0;
        unique case (step_reg)
            4'd0:  begin op_ia = 2'd1; op_ib = 2'd2; op_comp = 2'd0; end
            4'd1:  begin op_ia = 2'd2; op_ib = 2'd1; op_comp = 2'd0; op_sub = 1'b1; end
            4'd2:  begin op_ia = 2'd2; op_ib = 2'd0; op_comp = 2'd1; end
            4'd3:  begin op_ia = 2'd0; op_ib = 2'd2; op_comp = 2'd1; op_sub = 1'b1; end
            4'd4:  begin op_ia = 2'd0; op_ib = 2'd1; op_comp = 2'd2; end
            4'd5:  begin op_ia = 2'd1; op_ib = 2'd0; op_comp = 2'd2; op_sub = 1'b1; end
            4'd6:  begin op_kind = OP_SQ_LO;  op_comp = 2'd0; end
            4'd7:  begin op_kind = OP_SQ_MID; op_comp = 2'd0; end
            4'd8:  begin op_kind = OP_SQ_HI;  op_comp = 2'd0; end
            4'd9:  begin op_kind = OP_SQ_LO;  op_comp = 2'd1; end
            4'd10: begin op_kind = OP_SQ_MID; op_comp = 2'd1; end
            4'd11: begin op_kind = OP_SQ_HI;  op_comp = 2'd1; end
            4'd12: begin op_kind = OP_SQ_LO;  op_comp = 2'd2; end
            4'd13: begin op_kind = OP_SQ_MID; op_comp = 2'd2; end
            4'd14: begin op_kind = OP_SQ_HI;  op_comp = 2'd2; end
            default: begin op_kind = OP_SQ_HI; op_comp = 2'd2; end
        endcase
    end

    // operand magnitudes and sign
    always_comb
    begin
        opu     = u_reg[op_ia];
        opv     = v_reg[op_ib];
        opu_mag = opu[W-1] ? W'(-opu) : W'(opu);
        opv_mag = opv[W-1] ? W'(-opv) : W'(opv);
        prod_neg = opu[W-1] ^ opv[W-1] ^ op_sub;
        sq_src  = cross_reg[op_comp];
        sq_abs  = sq_src[CS-1] ? CS'(-sq_src) : CS'(sq_src);
        sq_mag  = sq_abs[C-1:0];
        unique case (op_kind)
            OP_CROSS:
            begin
                mul_a = H'(opu_mag);
                mul_b = H'(opv_mag);
            end
            OP_SQ_LO:
            begin
                mul_a = sq_mag[H-1:0];
                mul_b = sq_mag[H-1:0];
            end
            OP_SQ_MID:
            begin
                mul_a = H'(sq_mag >> H);
                mul_b = sq_mag[H-1:0];
            end
            default:
            begin
                mul_a = H'(sq_mag >> H);
                mul_b = H'(sq_mag >> H);
            end
        endcase
    end

    // root digit, area add, normal test, division step
    always_comb
    begin
        rem_sh   = {rem_reg[R:0], sumsq_reg[S-1:S-2]};
        trial    = {1'b0, root_reg, 2'b01};
        root_ge  = rem_sh >= trial;
        len_ext  = LW'(root_reg);
        len_big  = len_ext >= (LW'(1) << (AREA_BITS + 1));
        half     = (len_ext + LW'(1)) >> 1;
        area_sum = (AREA_BITS+2)'(area_reg) + (AREA_BITS+2)'(half[AREA_BITS:0]);
        face_full   = seen_reg == 2'd3;
        face_nvalid = face_full && (TW'(flen_reg) > TW'(tol_reg));
        div_abs  = fcross_reg[comp_reg][CS-1] ? CS'(-fcross_reg[comp_reg])
                                              : CS'(fcross_reg[comp_reg]);
        div_ge   = drem_reg >= dsh_reg;
        q_fin    = {q_reg[QW-2:0], div_ge};
        out_free = !out_valid_reg || out_ready;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        tol_next   = cfg_write_en ? cfg_write_data : tol_reg;
        first_next = first_reg;
        prev_next  = prev_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        cross_next = cross_reg;
        fcross_next = fcross_reg;
        flen_next  = flen_reg;
        seen_next  = seen_reg;
        area_next  = area_reg;
        sat_next   = sat_reg;
        face_next  = face_reg;
        last_next  = last_reg;
        step_next  = step_reg;
        prod_next  = prod_reg;
        sumsq_next = sumsq_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        cnt_next   = cnt_reg;
        comp_next  = comp_reg;
        drem_next  = drem_reg;
        dsh_next   = dsh_reg;
        q_next     = q_reg;
        norm_next  = norm_reg;
        out_valid_next = out_valid_reg && !out_ready;
        o_face_next   = o_face_reg;
        o_norm_next   = o_norm_reg;
        o_nvalid_next = o_nvalid_reg;
        o_area_next   = o_area_reg;
        o_sat_next    = o_sat_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    face_next = face_id;
                    last_next = last_vertex;
                    for (int i = 0; i < 3; i++)
                    begin
                        prev_next[i] = pin[i];
                        u_next[i] = W'(prev_reg[i]) - W'(first_reg[i]);
                        v_next[i] = W'(pin[i]) - W'(first_reg[i]);
                    end
                    priority if (seen_reg == 2'd0)
                    begin
                        first_next = pin;
                        area_next  = '0;
                        sat_next   = 1'b0;
                        seen_next  = 2'd1;
                        state_next = last_vertex ? ST_DONE : ST_IDLE;
                    end
                    else if (seen_reg == 2'd1)
                    begin
                        seen_next  = 2'd2;
                        state_next = last_vertex ? ST_DONE : ST_IDLE;
                    end
                    else
                    begin
                        step_next  = '0;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                prod_next  = mul_a * mul_b;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (op_kind == OP_CROSS)
                begin
                    cross_next[op_comp] = (op_sub ? cross_reg[op_comp] : CS'(0))
                        + (prod_neg ? -CS'(prod_reg) : CS'(prod_reg));
                end
                else
                begin
                    unique case (op_kind)
                        OP_SQ_LO:
                            sumsq_next = ((op_comp == 2'd0) ? S'(0) : sumsq_reg)
                                + S'(prod_reg);
                        OP_SQ_MID:
                            sumsq_next = sumsq_reg + (S'(prod_reg) << (H + 1));
                        default:
                            sumsq_next = sumsq_reg + (S'(prod_reg) << (2 * H));
                    endcase
                end
                step_next = step_reg + STEP_BITS'(1);
                if (step_reg == STEP_BITS'(OP_COUNT - 1))
                begin
                    rem_next   = '0;
                    root_next  = '0;
                    cnt_next   = '0;
                    state_next = ST_SQRT;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_SQRT:
            begin
                rem_next   = root_ge ? rem_sh - trial : rem_sh;
                root_next  = {root_reg[R-2:0], root_ge};
                sumsq_next = sumsq_reg << 2;
                cnt_next   = cnt_reg + CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(R - 1))
                begin
                    state_next = ST_AREA;
                end
            end
            ST_AREA:
            begin
                if (seen_reg == 2'd2)
                begin
                    fcross_next = cross_reg;
                    flen_next   = root_reg;
                    seen_next   = 2'd3;
                end
                if (len_big || area_sum > (AREA_BITS+2)'({AREA_BITS{1'b1}}))
                begin
                    area_next = '1;
                    sat_next  = 1'b1;
                end
                else
                begin
                    area_next = area_sum[AREA_BITS-1:0];
                end
                comp_next  = '0;
                state_next = last_reg ? ST_DIV_SET : ST_IDLE;
            end
            ST_DIV_SET:
            begin
                // skip the divider when the normal is invalid
                drem_next = (NW'(div_abs[C-1:0]) << QW) + NW'(flen_reg);
                dsh_next  = NW'({flen_reg, 1'b0}) << NORM_FRAC;
                q_next    = '0;
                cnt_next  = '0;
                state_next = face_nvalid ? ST_DIV : ST_DONE;
            end
            ST_DIV:
            begin
                if (div_ge)
                begin
                    drem_next = drem_reg - dsh_reg;
                end
                dsh_next = dsh_reg >> 1;
                q_next   = q_fin;
                cnt_next = cnt_reg + CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(NORM_FRAC))
                begin
                    norm_next[comp_reg] = fcross_reg[comp_reg][CS-1]
                        ? -NORM_BITS'(q_fin) : NORM_BITS'(q_fin);
                    comp_next  = comp_reg + 2'd1;
                    state_next = (comp_reg == 2'd2) ? ST_DONE : ST_DIV_SET;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_face_next    = face_reg;
                    o_nvalid_next  = face_nvalid;
                    for (int i = 0; i < 3; i++)
                    begin
                        o_norm_next[i] = face_nvalid ? norm_reg[i] : '0;
                    end
                    o_area_next = face_full ? area_reg : '0;
                    o_sat_next  = face_full && sat_reg;
                    seen_next   = '0;
                    area_next   = '0;
                    sat_next    = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tol_reg       <= TOL_RESET;
            seen_reg      <= '0;
            area_reg      <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tol_reg       <= tol_next;
            seen_reg      <= seen_next;
            area_reg      <= area_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        first_reg    <= first_next;
        prev_reg     <= prev_next;
        u_reg        <= u_next;
        v_reg        <= v_next;
        cross_reg    <= cross_next;
        fcross_reg   <= fcross_next;
        flen_reg     <= flen_next;
        face_reg     <= face_next;
        last_reg     <= last_next;
        step_reg     <= step_next;
        prod_reg     <= prod_next;
        sumsq_reg    <= sumsq_next;
        rem_reg      <= rem_next;
        root_reg     <= root_next;
        cnt_reg      <= cnt_next;
        comp_reg     <= comp_next;
        drem_reg     <= drem_next;
        dsh_reg      <= dsh_next;
        q_reg        <= q_next;
        norm_reg     <= norm_next;
        o_face_reg   <= o_face_next;
        o_norm_reg   <= o_norm_next;
        o_nvalid_reg <= o_nvalid_next;
        o_area_reg   <= o_area_next;
        o_sat_reg    <= o_sat_next;
    end

    // ports
    assign in_ready       = state_reg == ST_IDLE;
    assign out_valid      = out_valid_reg;
    assign result_face    = o_face_reg;
    assign normal_x       = o_norm_reg[0];
    assign normal_y       = o_norm_reg[1];
    assign normal_z       = o_norm_reg[2];
    assign normal_valid   = o_nvalid_reg;
    assign area           = o_area_reg;
    assign area_saturated = o_sat_reg;

    // checks
    `PNA_ASSERT_NOW(a_norm_zero, out_valid && !normal_valid,
        normal_x == '0 && normal_y == '0 && normal_z == '0)
    `PNA_ASSERT_NOW(a_sat_max, out_valid && area_saturated, area == {AREA_BITS{1'b1}})
    `PNA_ASSERT_NOW(a_valid_area, out_valid && normal_valid, area != '0)
    `PNA_ASSERT_NEXT(a_face_clear, state_reg == ST_DONE && out_free,
        seen_reg == 2'd0 && out_valid_reg)

endmodule
